### src/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define PIDC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define PIDC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/pidc_pkg.sv
// Types, constants and saturating fixed-point arithmetic of the PID step core.
`default_nettype none

package pidc_pkg;

  localparam int FRAC_BITS = 15;
  localparam int WORD_W    = 32;
  localparam int CFG_IDX_W = 3;

  typedef logic signed [WORD_W-1:0]   word_t;
  typedef logic signed [WORD_W:0]     sum_t;
  typedef logic signed [2*WORD_W-1:0] wide_t;

  localparam word_t SAT_MAX = word_t'(32'h7fff_ffff);
  localparam word_t SAT_NEG = -SAT_MAX;
  localparam wide_t ROUND   = wide_t'(1) <<< (FRAC_BITS - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN         = 3'd0,
    CFG_INTEG_GAIN        = 3'd1,
    CFG_DERIV_GAIN        = 3'd2,
    CFG_DERIV_FILTER_GAIN = 3'd3,
    CFG_OUT_UPPER_LIMIT   = 3'd4,
    CFG_OUT_LOWER_LIMIT   = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    word_t prop_gain;
    word_t integ_gain;
    word_t deriv_gain;
    word_t deriv_filter_gain;
    word_t out_upper_limit;
    word_t out_lower_limit;
  } cfg_t;

  // Rounded fixed-point product, saturated to the symmetric range.
  function automatic word_t mul_sat(input word_t a, input word_t b);
    wide_t prod;
    wide_t q;
    prod = a * b;
    q = (prod + ROUND) >>> FRAC_BITS;
    if (q > wide_t'(SAT_MAX)) begin
      mul_sat = SAT_MAX;
    end else if (q < wide_t'(SAT_NEG)) begin
      mul_sat = SAT_NEG;
    end else begin
      mul_sat = q[WORD_W-1:0];
    end
  endfunction

  // Negative saturation only applies when both operands are negative.
  function automatic word_t add_sat(input word_t a, input word_t b);
    sum_t s;
    s = sum_t'(a) + sum_t'(b);
    if (s > sum_t'(SAT_MAX)) begin
      add_sat = SAT_MAX;
    end else if (s < sum_t'(SAT_NEG) && a[WORD_W-1] && b[WORD_W-1]) begin
      add_sat = SAT_NEG;
    end else begin
      add_sat = s[WORD_W-1:0];
    end
  endfunction

  function automatic word_t sub_sat(input word_t a, input word_t b);
    sum_t s;
    s = sum_t'(a) - sum_t'(b);
    if (s > sum_t'(SAT_MAX)) begin
      sub_sat = SAT_MAX;
    end else if (s < sum_t'(SAT_NEG) && a[WORD_W-1] && !b[WORD_W-1] && b != '0) begin
      sub_sat = SAT_NEG;
    end else begin
      sub_sat = s[WORD_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

### src/pidc_in_if.sv
// Valid/ready channel that carries one input sample.
`default_nettype none

interface pidc_in_if;
  logic              valid;
  logic              ready;
  pidc_pkg::word_t   sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

### src/pidc_out_if.sv
// Valid/ready channel that carries one drive value.
`default_nettype none

interface pidc_out_if;
  logic              valid;
  logic              ready;
  pidc_pkg::word_t   drive;

  modport source (output valid, output drive, input ready);
  modport sink   (input valid, input drive, output ready);
endinterface

`default_nettype wire

### src/pid_controller_step_core.sv
// Top level of the fixed-point PID step core.
`default_nettype none

// Fixed-point PID controller: each sample (signed, 15 fraction bits) yields one
// drive value. The core is a five-register pipeline: input register, P and I
// products, state update (integrator with clamping and derivative filter),
// D product, and the output register. A sample is taken every cycle unless
// a stalled output has filled the pipeline; its drive value passes the
// registers in that order. A stalled output fills the empty stages before the
// input side stops. The state update stage sets the throughput of one sample
// per clock when the output is not stalled. The user must write gains and
// limits through the register port while the core is idle; the core itself
// does not enforce this. Indexes six and seven are ignored.
module pid_controller_step_core (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_wr_en,
  input  wire logic [pidc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire pidc_pkg::word_t                   cfg_data,
  pidc_in_if.sink                                sample_ch,
  pidc_out_if.source                             drive_ch
);

  pidc_pkg::cfg_t  cfg;
  logic [4:0]      vld;
  logic [4:0]      free;

  pidc_pkg::word_t x0;
  pidc_pkg::word_t x1;
  pidc_pkg::word_t p1;
  pidc_pkg::word_t i1;
  pidc_pkg::word_t y2;
  pidc_pkg::word_t diff2;
  pidc_pkg::word_t y3;
  pidc_pkg::word_t d3;
  pidc_pkg::word_t drive;
  pidc_pkg::word_t y_pi;
  pidc_pkg::word_t diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain         <= '0;
      cfg.integ_gain        <= '0;
      cfg.deriv_gain        <= '0;
      cfg.deriv_filter_gain <= '0;
      cfg.out_upper_limit   <= pidc_pkg::SAT_MAX;
      cfg.out_lower_limit   <= pidc_pkg::SAT_NEG;
    end else if (cfg_wr_en) begin
      unique case (pidc_pkg::cfg_idx_t'(cfg_index))
        pidc_pkg::CFG_PROP_GAIN:         cfg.prop_gain         <= cfg_data;
        pidc_pkg::CFG_INTEG_GAIN:        cfg.integ_gain        <= cfg_data;
        pidc_pkg::CFG_DERIV_GAIN:        cfg.deriv_gain        <= cfg_data;
        pidc_pkg::CFG_DERIV_FILTER_GAIN: cfg.deriv_filter_gain <= cfg_data;
        pidc_pkg::CFG_OUT_UPPER_LIMIT:   cfg.out_upper_limit   <= cfg_data;
        pidc_pkg::CFG_OUT_LOWER_LIMIT:   cfg.out_lower_limit   <= cfg_data;
        default: ;
      endcase
    end
  end

  // A stage can load when it is empty or its item moves on in this cycle.
  assign free[4] = !vld[4] || drive_ch.ready;
  assign free[3] = !vld[3] || free[4];
  assign free[2] = !vld[2] || free[3];
  assign free[1] = !vld[1] || free[2];
  assign free[0] = !vld[0] || free[1];

  assign sample_ch.ready = free[0];
  assign drive_ch.valid  = vld[4];
  assign drive_ch.drive  = drive;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (free[0]) vld[0] <= sample_ch.valid;
      if (free[1]) vld[1] <= vld[0];
      if (free[2]) vld[2] <= vld[1];
      if (free[3]) vld[3] <= vld[2];
      if (free[4]) vld[4] <= vld[3];
    end
  end

  pidc_state_stage u_state (
    .clk    (clk),
    .rst    (rst),
    .update (free[2] && vld[1]),
    .cfg    (cfg),
    .x      (x1),
    .p_term (p1),
    .i_prod (i1),
    .y      (y_pi),
    .diff   (diff)
  );

  always_ff @(posedge clk) begin
    if (free[0]) begin
      x0 <= sample_ch.sample;
    end
    if (free[1]) begin
      x1 <= x0;
      p1 <= pidc_pkg::mul_sat(x0, cfg.prop_gain);
      i1 <= pidc_pkg::mul_sat(cfg.integ_gain, x0);
    end
    if (free[2]) begin
      y2    <= y_pi;
      diff2 <= diff;
    end
    if (free[3]) begin
      y3 <= y2;
      d3 <= pidc_pkg::mul_sat(diff2, cfg.deriv_gain);
    end
    if (free[4]) begin
      drive <= pidc_pkg::add_sat(y3, d3);
    end
  end

endmodule

`default_nettype wire

### src/pidc_state_stage.sv
// Integrator and derivative filter state with their combinational update logic.
`default_nettype none

module pidc_state_stage (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            update,
  input  wire pidc_pkg::cfg_t  cfg,
  input  wire pidc_pkg::word_t x,
  input  wire pidc_pkg::word_t p_term,
  input  wire pidc_pkg::word_t i_prod,
  output pidc_pkg::word_t      y,
  output pidc_pkg::word_t      diff
);

  pidc_pkg::word_t integ_acc;
  pidc_pkg::word_t integ_acc_next;
  pidc_pkg::word_t deriv_state;
  pidc_pkg::word_t deriv_state_next;
  pidc_pkg::word_t acc_sum;
  pidc_pkg::word_t y_sum;

  always_comb begin
    acc_sum        = pidc_pkg::add_sat(integ_acc, i_prod);
    y_sum          = pidc_pkg::add_sat(p_term, acc_sum);
    y              = p_term;
    integ_acc_next = integ_acc;
    if (cfg.integ_gain != '0) begin
      // On a clamp the accumulator is rebuilt so that P plus I lands on the limit.
      if (y_sum > cfg.out_upper_limit) begin
        integ_acc_next = pidc_pkg::sub_sat(cfg.out_upper_limit, p_term);
        y              = cfg.out_upper_limit;
      end else if (y_sum < cfg.out_lower_limit) begin
        integ_acc_next = pidc_pkg::sub_sat(cfg.out_lower_limit, p_term);
        y              = cfg.out_lower_limit;
      end else begin
        integ_acc_next = acc_sum;
        y              = y_sum;
      end
    end

    diff             = '0;
    deriv_state_next = deriv_state;
    if (cfg.deriv_filter_gain != '0) begin
      diff             = pidc_pkg::sub_sat(x, deriv_state);
      deriv_state_next = deriv_state + pidc_pkg::mul_sat(cfg.deriv_filter_gain, diff);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integ_acc   <= '0;
      deriv_state <= '0;
    end else if (update) begin
      integ_acc   <= integ_acc_next;
      deriv_state <= deriv_state_next;
    end
  end

endmodule

`default_nettype wire

### src/pidc_checker.sv
// Port-level checks of the PID step core and the bind that attaches them.
`default_nettype none
`include "assert_macros.svh"

module pidc_checker (
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            in_valid,
  input wire logic            in_ready,
  input wire logic            out_valid,
  input wire logic            out_ready,
  input wire pidc_pkg::word_t drive
);

  `PIDC_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(drive), "drive changed while stalled")
  `PIDC_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid && in_ready, "pipeline not empty after reset")
  `PIDC_ASSERT(a_ready_stall, clk, rst, !in_ready |-> out_valid && !out_ready, "input blocked without an output stall")
  `PIDC_ASSERT(a_in_stall, clk, rst, in_valid && !in_ready |=> !out_valid || $past(out_valid), "output appeared from an empty stalled pipeline")

endmodule

bind pid_controller_step_core pidc_checker u_pidc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (sample_ch.valid),
  .in_ready  (sample_ch.ready),
  .out_valid (drive_ch.valid),
  .out_ready (drive_ch.ready),
  .drive     (drive_ch.drive)
);

`default_nettype wire

### dv/tb_pid_controller_step_core.sv
// Self-checking testbench of the PID step core: predicts every drive value and compares it.
`default_nettype none

module tb_pid_controller_step_core;

  localparam int     HALF_PERIOD     = 6;
  localparam int     CFG_SETTLE      = 8;
  localparam int     STALL_LIMIT     = 2000;
  localparam int     HOLD_CYCLES     = 60;
  localparam int     N_PHASES        = 12;
  localparam int     ITEMS_PER_PHASE = 86;

  localparam logic [pidc_pkg::CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [pidc_pkg::CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

  localparam pidc_pkg::word_t W_MAX = pidc_pkg::word_t'(32'h7fff_ffff);
  localparam pidc_pkg::word_t W_MIN = pidc_pkg::word_t'(32'h8000_0000);
  localparam pidc_pkg::word_t UNITY = pidc_pkg::word_t'(32'h0000_8000);

  // Mirror of the controller: gains, limits, integrator and derivative filter.
  class drive_tracker;
    localparam longint LIM = 64'sh7fff_ffff;

    pidc_pkg::word_t kp, ki, kd, kf, hi_lim, lo_lim;
    pidc_pkg::word_t integ_acc, deriv_state;
    pidc_pkg::word_t pending_drive[$];
    int    failures;

    function new();
      kp = '0; ki = '0; kd = '0; kf = '0;
      hi_lim = W_MAX;
      lo_lim = -W_MAX;
      integ_acc = '0;
      deriv_state = '0;
      failures = 0;
    endfunction

    function pidc_pkg::word_t fx_mul(pidc_pkg::word_t a, pidc_pkg::word_t b);
      longint q;
      q = (longint'(a) * longint'(b) + (longint'(1) <<< (pidc_pkg::FRAC_BITS - 1)))
          >>> pidc_pkg::FRAC_BITS;
      if (q > LIM) q = LIM;
      if (q < -LIM) q = -LIM;
      return pidc_pkg::word_t'(q);
    endfunction

    function pidc_pkg::word_t fx_add(pidc_pkg::word_t a, pidc_pkg::word_t b);
      longint s;
      s = longint'(a) + longint'(b);
      if (s > LIM) return pidc_pkg::word_t'(LIM);
      if (s < -LIM && a < 0 && b < 0) return pidc_pkg::word_t'(-LIM);
      return pidc_pkg::word_t'(s);
    endfunction

    function pidc_pkg::word_t fx_sub(pidc_pkg::word_t a, pidc_pkg::word_t b);
      longint s;
      s = longint'(a) - longint'(b);
      if (s > LIM) return pidc_pkg::word_t'(LIM);
      if (s < -LIM && a < 0 && b > 0) return pidc_pkg::word_t'(-LIM);
      return pidc_pkg::word_t'(s);
    endfunction

    function void set_reg(logic [pidc_pkg::CFG_IDX_W-1:0] idx, pidc_pkg::word_t v);
      case (idx)
        pidc_pkg::CFG_PROP_GAIN:         kp = v;
        pidc_pkg::CFG_INTEG_GAIN:        ki = v;
        pidc_pkg::CFG_DERIV_GAIN:        kd = v;
        pidc_pkg::CFG_DERIV_FILTER_GAIN: kf = v;
        pidc_pkg::CFG_OUT_UPPER_LIMIT:   hi_lim = v;
        pidc_pkg::CFG_OUT_LOWER_LIMIT:   lo_lim = v;
        default: ;
      endcase
    endfunction

    function pidc_pkg::word_t predict_drive(pidc_pkg::word_t x);
      pidc_pkg::word_t p_term, y, diff;
      p_term = fx_mul(x, kp);
      y = p_term;
      diff = '0;
      if (ki != 0) begin
        integ_acc = fx_add(integ_acc, fx_mul(ki, x));
        y = fx_add(y, integ_acc);
        // The upper limit is checked first, so it wins when both limits are crossed, as with inverted limits.
        if (y > hi_lim) begin
          integ_acc = fx_sub(hi_lim, p_term);
          y = hi_lim;
        end else if (y < lo_lim) begin
          integ_acc = fx_sub(lo_lim, p_term);
          y = lo_lim;
        end
      end
      if (kf != 0) begin
        diff = fx_sub(x, deriv_state);
        deriv_state = deriv_state + fx_mul(kf, diff);
      end
      return fx_add(y, fx_mul(diff, kd));
    endfunction

    function void note_sample(pidc_pkg::word_t x);
      pending_drive.push_back(predict_drive(x));
    endfunction

    function void check_drive(pidc_pkg::word_t y);
      pidc_pkg::word_t exp_y;
      if (pending_drive.size() == 0) begin
        $display("%0t: drive %0d arrived with no sample outstanding", $time, y);
        failures++;
      end else begin
        exp_y = pending_drive.pop_front();
        if (y !== exp_y) begin
          $display("%0t: drive mismatch, expected %0d, actual %0d", $time, exp_y, y);
          failures++;
        end
      end
    endfunction

    function int pending_count();
      return pending_drive.size();
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           cfg_wr_en;
  logic [pidc_pkg::CFG_IDX_W-1:0] cfg_index;
  pidc_pkg::word_t                cfg_data;

  pidc_in_if  sample_if();
  pidc_out_if drive_if();

  drive_tracker tracker = new();

  int tx_idle_pct;
  int rx_idle_pct;
  bit rx_hold_req;
  int quiet_cycles;

  pid_controller_step_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample_ch (sample_if),
    .drive_ch  (drive_if)
  );

  always #HALF_PERIOD clk = ~clk;

  // Receiver: checks each output transfer and drives ready, with an
  // occasional long hold-off that backs the pipeline up into the input.
  initial begin
    int hold_left;
    hold_left = 0;
    drive_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && drive_if.valid && drive_if.ready) begin
        tracker.check_drive(drive_if.drive);
      end
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        drive_if.ready <= 1'b0;
      end else begin
        drive_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (sample_if.valid && sample_if.ready) || (drive_if.valid && drive_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(logic [pidc_pkg::CFG_IDX_W-1:0] idx, pidc_pkg::word_t v);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    tracker.set_reg(idx, v);
  endtask

  task automatic wait_idle();
    while (tracker.pending_count() != 0) @(posedge clk);
    repeat (CFG_SETTLE) @(posedge clk);
  endtask

  task automatic apply_config(pidc_pkg::word_t kp, pidc_pkg::word_t ki,
                              pidc_pkg::word_t kd, pidc_pkg::word_t kf,
                              pidc_pkg::word_t hi, pidc_pkg::word_t lo);
    wait_idle();
    // Unused indexes must leave every register alone.
    write_reg(CFG_SPARE_6, pidc_pkg::word_t'($urandom));
    write_reg(CFG_SPARE_7, pidc_pkg::word_t'($urandom));
    write_reg(pidc_pkg::CFG_PROP_GAIN, kp);
    write_reg(pidc_pkg::CFG_INTEG_GAIN, ki);
    write_reg(pidc_pkg::CFG_DERIV_GAIN, kd);
    write_reg(pidc_pkg::CFG_DERIV_FILTER_GAIN, kf);
    write_reg(pidc_pkg::CFG_OUT_UPPER_LIMIT, hi);
    write_reg(pidc_pkg::CFG_OUT_LOWER_LIMIT, lo);
    cfg_wr_en <= 1'b0;
  endtask

  // Valid stays high from one sample to the next; it drops only on a gap or at the end of a burst.
  task automatic send_sample(pidc_pkg::word_t x);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      sample_if.valid <= 1'b0;
      @(posedge clk);
    end
    sample_if.valid  <= 1'b1;
    sample_if.sample <= x;
    @(posedge clk);
    while (!sample_if.ready) @(posedge clk);
    tracker.note_sample(x);
  endtask

  task automatic end_burst();
    sample_if.valid <= 1'b0;
  endtask

  task automatic set_idle(int ph);
    if (ph < 4) begin
      tx_idle_pct = 6;
      rx_idle_pct = 57;
    end else if (ph < 8) begin
      tx_idle_pct = 57;
      rx_idle_pct = 6;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
  endtask

  function automatic pidc_pkg::word_t pick_extreme();
    case ($urandom_range(0, 4))
      0:       return W_MIN;
      1:       return W_MAX;
      2:       return '0;
      3:       return -1;
      default: return 1;
    endcase
  endfunction

  function automatic pidc_pkg::word_t rand_sample();
    case ($urandom_range(0, 9))
      0:          return pick_extreme();
      1, 2, 3:    return pidc_pkg::word_t'($urandom);
      default:    return pidc_pkg::word_t'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
    endcase
  endfunction

  function automatic pidc_pkg::word_t rand_gain();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return pick_extreme();
      2, 3:    return pidc_pkg::word_t'($urandom);
      default: return pidc_pkg::word_t'(int'($urandom_range(0, 1 << 17)) - (1 << 16));
    endcase
  endfunction

  task automatic pick_limits(output pidc_pkg::word_t hi, output pidc_pkg::word_t lo);
    pidc_pkg::word_t a, b;
    a = pidc_pkg::word_t'($urandom);
    b = pidc_pkg::word_t'($urandom);
    case ($urandom_range(0, 4))
      0: begin
        hi = W_MAX;
        lo = -W_MAX;
      end
      1: begin
        hi = W_MAX;
        lo = W_MIN;
      end
      2: begin
        hi = (a > b) ? a : b;
        lo = (a > b) ? b : a;
      end
      3: begin
        hi = pidc_pkg::word_t'($urandom_range(0, 1 << 22));
        lo = -pidc_pkg::word_t'($urandom_range(0, 1 << 22));
      end
      default: begin
        hi = -pidc_pkg::word_t'($urandom_range(1, 1 << 20));
        lo = pidc_pkg::word_t'($urandom_range(1, 1 << 20));
      end
    endcase
  endtask

  initial begin
    pidc_pkg::word_t hi, lo;
    rst              <= 1'b1;
    cfg_wr_en        <= 1'b0;
    cfg_index        <= '0;
    cfg_data         <= '0;
    sample_if.valid  <= 1'b0;
    sample_if.sample <= '0;
    rx_hold_req      = 1'b0;
    set_idle(0);
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: every gain is zero.
    send_sample('0); send_sample(W_MAX); send_sample(W_MIN);
    end_burst();

    // Unity P and I: two most negative terms meet in the output sum. The
    // derivative gain is large but the filter is off, so no derivative term.
    apply_config(UNITY, UNITY, W_MAX, '0, W_MAX, -W_MAX);
    send_sample(W_MIN); send_sample(W_MIN); send_sample(W_MAX); send_sample(W_MAX);
    send_sample('0); send_sample(-1); send_sample(1);
    end_burst();

    // Derivative only: the filter state reaches the most negative value,
    // so the next zero sample forms zero minus most negative.
    apply_config('0, '0, UNITY, UNITY, W_MAX, -W_MAX);
    send_sample(W_MIN); send_sample(W_MIN); send_sample('0); send_sample(W_MAX);
    send_sample(1);
    end_burst();

    // Inverted limits.
    apply_config(UNITY, 1, '0, '0, -100, 100);
    send_sample(1000); send_sample(-1000); send_sample('0); send_sample(50);
    end_burst();

    apply_config(W_MIN, W_MIN, W_MIN, W_MIN, W_MAX, W_MIN);
    send_sample(W_MAX); send_sample(W_MIN); send_sample(-1);
    end_burst();

    apply_config(W_MAX, W_MAX, W_MAX, W_MAX, W_MIN, W_MAX);
    send_sample(W_MAX); send_sample(W_MIN); send_sample(1);
    end_burst();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      pick_limits(hi, lo);
      apply_config(rand_gain(), rand_gain(), rand_gain(), rand_gain(), hi, lo);
      set_idle(ph);
      if (ph == 8 || ph == 10) rx_hold_req = 1'b1;
      repeat (ITEMS_PER_PHASE) send_sample(rand_sample());
      end_burst();
    end

    wait_idle();
    if (tracker.pending_count() != 0) begin
      $display("%0t: %0d drive values never arrived", $time, tracker.pending_count());
    end
    if (tracker.failures == 0 && tracker.pending_count() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
